/* hdl/merge_sorter_unit_macros.svh */
// ----------------------------------------------------------------------------
// Merge sorter assertion macros
// Shared assertion helpers for the merge sorter; NO_ASSERTIONS removes them.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_UNIT_MACROS_SVH
`define MERGE_SORTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A condition that must hold at every clock edge out of reset.
`define MSU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MSU_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`else

`define MSU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define MSU_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)

`endif

`endif

/* hdl/msu_pkg.sv */
// ----------------------------------------------------------------------------
// Merge sorter package
// Sequencer states and the fixed data width shared by the merge sorter modules.
// ----------------------------------------------------------------------------
package msu_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_MSETUP,
        ST_MREAD,
        ST_MCMP,
        ST_OREAD,
        ST_OLOAD,
        ST_OWAIT
    } msu_state_t;

endpackage

/* hdl/merge_sorter_unit.sv */
// ----------------------------------------------------------------------------
// Merge sorter unit
// A set of n words is collected at one word per cycle; the sort then runs
// ceil(log2(n)) merge passes, with a setup state per run pair and a read
// and a compare state per word, through one shared compare unit and two
// RAM banks. Output reads, loads and offers each word, waiting out any
// stall. Reset (rst_n, async, active low) empties the set.
// ----------------------------------------------------------------------------
`include "merge_sorter_unit_macros.svh"

module merge_sorter_unit
    import msu_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     end_of_set,
    output logic                     dropped
);

    // AW addresses one bank entry, CW holds a count up to MAX_ITEMS, and
    // SW holds the run bounds lo + 2*width without wrapping.
    localparam int unsigned AW  = $clog2(MAX_ITEMS);
    localparam int unsigned CW  = $clog2(MAX_ITEMS + 1);
    localparam int unsigned SW  = CW + 2;
    localparam int unsigned PAD = SW - CW;

    localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

    // Sequencer state and bookkeeping registers.
    msu_state_t state_reg, state_next;

    logic [CW-1:0] fill_count_reg, fill_count_next;
    logic          overflow_reg, overflow_next;
    logic [CW-1:0] n_reg, n_next;
    logic [SW-1:0] width_reg, width_next;
    logic [SW-1:0] lo_reg, lo_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] out_idx_reg, out_idx_next;
    logic          bank_sel_reg, bank_sel_next;

    // Output register, which holds a word until the consumer takes it.
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] sorted_value_reg, sorted_value_next;
    logic                     end_of_set_reg, end_of_set_next;
    logic                     dropped_reg, dropped_next;

    logic in_accept;
    logic out_accept;

    // RAM bank connections. Bank 0 receives the collected set; each merge
    // pass reads the bank selected by bank_sel_reg and writes the other one.
    logic              we0, we1;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic [DATA_W-1:0] rd_a, rd_b;

    // Run geometry for the current run pair.
    logic [SW-1:0] n_ext;
    logic [SW-1:0] two_w;
    logic [SW-1:0] mid_sum, hi_sum, mid, hi;
    logic [SW-1:0] lo_step;
    logic [SW-1:0] i_ext, j_ext, k_inc_ext;
    logic [CW-1:0] k_inc;
    logic          take_i;
    logic          run_end, pass_end, sort_end;
    logic          last_out;

    assign in_accept  = in_valid && in_ready;
    assign out_accept = out_valid_reg && out_ready;

    assign n_ext   = {{PAD{1'b0}}, n_reg};
    assign two_w   = width_reg << 1;
    assign mid_sum = lo_reg + width_reg;
    assign hi_sum  = lo_reg + two_w;
    assign mid     = (mid_sum > n_ext) ? n_ext : mid_sum;
    assign hi      = (hi_sum > n_ext) ? n_ext : hi_sum;
    assign lo_step = hi_sum;

    assign i_ext     = {{PAD{1'b0}}, i_reg};
    assign j_ext     = {{PAD{1'b0}}, j_reg};
    assign k_inc     = k_reg + 1'b1;
    assign k_inc_ext = {{PAD{1'b0}}, k_inc};

    assign rd_a = bank_sel_reg ? rd1_a : rd0_a;
    assign rd_b = bank_sel_reg ? rd1_b : rd0_b;

    // The shared compare unit: take the left head while the left run has
    // words and either the right run is used up or the left head is smaller.
    assign take_i = (i_ext < mid) &&
                    ((j_ext >= hi) || ($signed(rd_a) < $signed(rd_b)));

    // A run pair ends with its last merged word; a pass ends when the next
    // pair would start beyond the set; the sort ends once one run spans it.
    assign run_end  = (k_inc_ext == hi);
    assign pass_end = run_end && (lo_step >= n_ext);
    assign sort_end = pass_end && (two_w >= n_ext);

    assign last_out = ((out_idx_reg + 1'b1) == n_reg);

    msu_ram #(
        .DEPTH (MAX_ITEMS)
    ) u_bank0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    msu_ram #(
        .DEPTH (MAX_ITEMS)
    ) u_bank1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_accept && last)
                begin
                    // A set of one word is already in order.
                    if (fill_count_next > CW'(1))
                    begin
                        state_next = ST_MSETUP;
                    end
                    else
                    begin
                        state_next = ST_OREAD;
                    end
                end
            end
            ST_MSETUP:
            begin
                state_next = ST_MREAD;
            end
            ST_MREAD:
            begin
                state_next = ST_MCMP;
            end
            ST_MCMP:
            begin
                if (sort_end)
                begin
                    state_next = ST_OREAD;
                end
                else if (run_end)
                begin
                    state_next = ST_MSETUP;
                end
                else
                begin
                    state_next = ST_MREAD;
                end
            end
            ST_OREAD:
            begin
                state_next = ST_OLOAD;
            end
            ST_OLOAD:
            begin
                state_next = ST_OWAIT;
            end
            ST_OWAIT:
            begin
                if (out_accept)
                begin
                    state_next = end_of_set_reg ? ST_COLLECT : ST_OREAD;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Handshake and RAM port controls.
    always_comb
    begin
        in_ready = 1'b0;
        we0      = 1'b0;
        we1      = 1'b0;
        waddr    = k_reg[AW-1:0];
        wdata    = take_i ? rd_a : rd_b;
        raddr_a  = i_reg[AW-1:0];
        raddr_b  = j_reg[AW-1:0];
        case (state_reg)
            ST_COLLECT:
            begin
                in_ready = 1'b1;
                waddr    = fill_count_reg[AW-1:0];
                wdata    = value;
                we0      = in_accept && (fill_count_reg < CAP);
            end
            ST_MCMP:
            begin
                we0 = bank_sel_reg;
                we1 = !bank_sel_reg;
            end
            ST_OREAD:
            begin
                raddr_a = out_idx_reg[AW-1:0];
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath: counters, run bounds and the output register.
    always_comb
    begin
        fill_count_next   = fill_count_reg;
        overflow_next     = overflow_reg;
        n_next            = n_reg;
        width_next        = width_reg;
        lo_next           = lo_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        out_idx_next      = out_idx_reg;
        bank_sel_next     = bank_sel_reg;
        out_valid_next    = out_valid_reg;
        sorted_value_next = sorted_value_reg;
        end_of_set_next   = end_of_set_reg;
        dropped_next      = dropped_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_accept)
                begin
                    // A word that finds the set full is dropped, even the
                    // last one, which still closes the set.
                    if (fill_count_reg < CAP)
                    begin
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last)
                    begin
                        n_next        = fill_count_next;
                        width_next    = SW'(1);
                        lo_next       = '0;
                        bank_sel_next = 1'b0;
                        out_idx_next  = '0;
                    end
                end
            end
            ST_MSETUP:
            begin
                i_next = lo_reg[CW-1:0];
                j_next = mid[CW-1:0];
                k_next = lo_reg[CW-1:0];
            end
            ST_MCMP:
            begin
                k_next = k_inc;
                if (take_i)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                if (pass_end)
                begin
                    width_next    = two_w;
                    lo_next       = '0;
                    bank_sel_next = !bank_sel_reg;
                end
                else if (run_end)
                begin
                    lo_next = lo_step;
                end
            end
            ST_OLOAD:
            begin
                out_valid_next    = 1'b1;
                sorted_value_next = rd_a;
                end_of_set_next   = last_out;
                dropped_next      = overflow_reg;
            end
            ST_OWAIT:
            begin
                if (out_accept)
                begin
                    out_valid_next = 1'b0;
                    out_idx_next   = out_idx_reg + 1'b1;
                    if (end_of_set_reg)
                    begin
                        fill_count_next = '0;
                        overflow_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            fill_count_reg <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            bank_sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
            bank_sel_reg   <= bank_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg            <= n_next;
        width_reg        <= width_next;
        lo_reg           <= lo_next;
        i_reg            <= i_next;
        j_reg            <= j_next;
        k_reg            <= k_next;
        out_idx_reg      <= out_idx_next;
        sorted_value_reg <= sorted_value_next;
        end_of_set_reg   <= end_of_set_next;
        dropped_reg      <= dropped_next;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign end_of_set   = end_of_set_reg;
    assign dropped      = dropped_reg;

    // The block never takes input while a sorted word is on offer.
    `MSU_ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(in_ready && out_valid_reg), "in/out overlap")
    // The fill count never passes the capacity of a bank.
    `MSU_ASSERT_ALWAYS(a_fill_cap, clk, rst_n, fill_count_reg <= CAP, "fill count beyond capacity")
    // A merge write always lands inside the current run pair.
    `MSU_ASSERT_ALWAYS(a_k_in_run, clk, rst_n, !(state_reg == ST_MCMP) || (k_inc_ext <= hi), "merge write outside run")
    // Closing a set stops input until its sorted words are out.
    `MSU_ASSERT_NEXT(a_last_stops, clk, rst_n, in_accept && last, !in_ready, "input taken after last")
    // Handing over the final word reopens the block for a new set.
    `MSU_ASSERT_NEXT(a_reopen, clk, rst_n, out_accept && end_of_set_reg, in_ready && (fill_count_reg == '0), "not reopened after set")

endmodule

/* hdl/msu_ram.sv */
// ----------------------------------------------------------------------------
// Merge sorter RAM bank
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module msu_ram
    import msu_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [DATA_W-1:0]        rdata_a,
    output logic [DATA_W-1:0]        rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
